>>> src/lpg_pkg.sv
// shared types for the line point generator
// no dependencies
`default_nettype none

package lpg_pkg;

  // control from the sequencer to the minor-axis accumulator
  typedef struct packed {
    logic load;  // start a new run: take span and minor magnitude
    logic step;  // advance one point along the major axis
  } acc_ctrl_t;

endpackage : lpg_pkg

`default_nettype wire

>>> src/lpg_minor_acc.sv
// minor-axis error accumulator, one compare-subtract per step
// depends on lpg_pkg
`default_nettype none

module lpg_minor_acc import lpg_pkg::*; #(
  parameter int SPAN_BITS = 6
) (
  input  wire logic                 clk,
  input  wire acc_ctrl_t            ctrl,
  input  wire logic [SPAN_BITS-1:0] span,
  input  wire logic [SPAN_BITS-1:0] minor_mag,
  output logic                      carry
);

  localparam int ACC_BITS = SPAN_BITS + 2;

  logic [SPAN_BITS-1:0] span_r;
  logic [SPAN_BITS-1:0] mag_r;
  logic [ACC_BITS-1:0]  rem;
  logic [ACC_BITS-1:0]  rem_next;
  logic [ACC_BITS-1:0]  sum;
  logic [ACC_BITS-1:0]  span2;

  // remainder of (2*i*m + s) over 2*s stays below 2*s
  assign span2 = {1'b0, span_r, 1'b0};
  assign sum   = rem + {1'b0, mag_r, 1'b0};
  assign carry = (sum >= span2);

  always_comb begin
    if (carry) begin
      rem_next = sum - span2;
    end else begin
      rem_next = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      span_r <= span;
      mag_r  <= minor_mag;
      rem    <= {2'b00, span};
    end else if (ctrl.step) begin
      rem <= rem_next;
    end
  end

endmodule : lpg_minor_acc

`default_nettype wire

>>> src/line_point_generator.sv
// line point generator top level: sequencer, point registers, output register
// depends on lpg_pkg and lpg_minor_acc
// a request passes through S_DIFF and S_PLAN to S_RUN, which registers each point into the output word
// a new request is taken only in S_IDLE, after the last point of the previous one has been emitted
// the minor-axis accumulator does one add and compare-subtract per step between points
// reset: synchronous active-high rst clears the sequencer and output valid
`default_nettype none

module line_point_generator import lpg_pkg::*; #(
  parameter int MAX_SPAN   = 63,
  parameter int COORD_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] start_x,
  input  wire logic [15:0] start_y,
  input  wire logic [15:0] end_x,
  input  wire logic [15:0] end_y,
  // point channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      point_x,
  output logic [15:0]      point_y,
  output logic             last_point,
  output logic             span_error
);

  localparam int CW        = COORD_BITS;
  localparam int DW        = COORD_BITS + 1;
  localparam int SPAN_BITS = $clog2(MAX_SPAN + 1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a request
  localparam logic [1:0] S_DIFF = 2'd1;  // endpoint differences
  localparam logic [1:0] S_PLAN = 2'd2;  // axis choice, span check
  localparam logic [1:0] S_RUN  = 2'd3;  // one point per free output slot

  logic [1:0] state;
  logic [1:0] state_next;

  // coordinates read at COORD_BITS width
  logic [CW-1:0] sx_in, sy_in, ex_in, ey_in;

  generate
    if (CW <= 16) begin : g_narrow_in
      assign sx_in = start_x[CW-1:0];
      assign sy_in = start_y[CW-1:0];
      assign ex_in = end_x[CW-1:0];
      assign ey_in = end_y[CW-1:0];
    end else begin : g_wide_in
      // 16-bit fields seen at a wider width are never negative
      assign sx_in = {{(CW-16){1'b0}}, start_x};
      assign sy_in = {{(CW-16){1'b0}}, start_y};
      assign ex_in = {{(CW-16){1'b0}}, end_x};
      assign ey_in = {{(CW-16){1'b0}}, end_y};
    end
  endgenerate

  // request and current point
  logic [CW-1:0] px, py, ex, ey;
  logic [DW-1:0] dx, dy;

  // run setup
  logic                 x_major;
  logic                 maj_neg;
  logic                 min_neg;
  logic                 err;
  logic [SPAN_BITS-1:0] cnt;

  // plan stage values
  logic [DW-1:0]        adx, ady;
  logic                 plan_x_major;
  logic [DW-1:0]        plan_span;
  logic [DW-1:0]        plan_mag;
  logic                 plan_too_long;
  logic [SPAN_BITS-1:0] plan_span_n;
  logic [SPAN_BITS-1:0] plan_mag_n;

  assign adx = dx[DW-1] ? (~dx + DW'(1)) : dx;
  assign ady = dy[DW-1] ? (~dy + DW'(1)) : dy;
  // ties go to x
  assign plan_x_major  = (adx >= ady);
  assign plan_span     = plan_x_major ? adx : ady;
  assign plan_mag      = plan_x_major ? ady : adx;
  assign plan_too_long = (plan_span > DW'(MAX_SPAN));
  assign plan_span_n   = plan_span[SPAN_BITS-1:0];
  assign plan_mag_n    = plan_mag[SPAN_BITS-1:0];

  // output slot is free when empty or being taken this cycle
  logic out_free;
  logic emit;
  logic emit_last;
  assign out_free  = !out_valid || !out_stall;
  assign emit      = (state == S_RUN) && out_free;
  assign emit_last = (cnt == '0);

  assign in_stall = (state != S_IDLE);

  // minor-axis accumulator
  acc_ctrl_t acc_ctrl;
  logic      carry;

  assign acc_ctrl.load = (state == S_PLAN);
  assign acc_ctrl.step = emit && !emit_last;

  lpg_minor_acc #(
    .SPAN_BITS(SPAN_BITS)
  ) u_minor_acc (
    .clk      (clk),
    .ctrl     (acc_ctrl),
    .span     (plan_span_n),
    .minor_mag(plan_mag_n),
    .carry    (carry)
  );

  // next point: major moves one unit, minor moves one unit on carry
  logic [CW-1:0] maj_step;
  logic [CW-1:0] min_step;
  assign maj_step = maj_neg ? {CW{1'b1}} : CW'(1);
  assign min_step = !carry ? '0 : (min_neg ? {CW{1'b1}} : CW'(1));

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DIFF;
        end
      end
      S_DIFF: begin
        state_next = S_PLAN;
      end
      S_PLAN: begin
        state_next = S_RUN;
      end
      S_RUN: begin
        if (emit && emit_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          px <= sx_in;
          py <= sy_in;
          ex <= ex_in;
          ey <= ey_in;
        end
      end
      S_DIFF: begin
        dx <= {ex[CW-1], ex} - {px[CW-1], px};
        dy <= {ey[CW-1], ey} - {py[CW-1], py};
      end
      S_PLAN: begin
        x_major <= plan_x_major;
        maj_neg <= plan_x_major ? dx[DW-1] : dy[DW-1];
        min_neg <= plan_x_major ? dy[DW-1] : dx[DW-1];
        err     <= plan_too_long;
        // zero span and overlong span both give the start point alone
        if (plan_too_long) begin
          cnt <= '0;
        end else begin
          cnt <= plan_span_n;
        end
      end
      S_RUN: begin
        if (emit && !emit_last) begin
          cnt <= cnt - SPAN_BITS'(1);
          if (x_major) begin
            px <= px + maj_step;
            py <= py + min_step;
          end else begin
            px <= px + min_step;
            py <= py + maj_step;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // output word register
  logic [15:0] px_out, py_out;

  generate
    if (CW < 16) begin : g_narrow_out
      // coordinates wrap at COORD_BITS and are given zero-extended
      assign px_out = {{(16-CW){1'b0}}, px};
      assign py_out = {{(16-CW){1'b0}}, py};
    end else begin : g_wide_out
      assign px_out = px[15:0];
      assign py_out = py[15:0];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      point_x    <= px_out;
      point_y    <= py_out;
      last_point <= emit_last;
      span_error <= err;
    end
  end

endmodule : line_point_generator

`default_nettype wire

>>> tb/tb_line_point_generator.sv
// self-checking testbench for line_point_generator: directed and random line requests
// depends on the line_point_generator rtl only; predicts every point word and checks it
`timescale 1ns / 1ps

module tb_line_point_generator;

  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int SPAN_LIMIT  = 63;
  localparam int RAND_LINES  = 305;
  // the receiver blocks for a long stretch once this many requests went in
  localparam int HOLD_AT     = 80;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [15:0] sx;
    logic [15:0] sy;
    logic [15:0] ex;
    logic [15:0] ey;
    int          gap;
    bit          drain_first;
  } line_req_t;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic        last;
    logic        err;
  } point_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] start_x = '0;
  logic [15:0] start_y = '0;
  logic [15:0] end_x = '0;
  logic [15:0] end_y = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] point_x;
  logic [15:0] point_y;
  logic        last_point;
  logic        span_error;

  line_req_t line_reqs[$];
  point_t    line_points[$];

  int  n_accepted = 0;
  int  outstanding = 0;
  int  gap_left = 0;
  bit  gap_loaded = 1'b0;
  int  hold_cnt = 0;
  bit  hold_done = 1'b0;
  int  stall_left = 0;
  bit  calm = 1'b0;
  int  cycle = 0;
  int  n_fail = 0;
  int  n_words = 0;
  int  n_lines = 0;
  int  n_over = 0;
  int  n_single = 0;

  line_point_generator #(
    .MAX_SPAN  (SPAN_LIMIT),
    .COORD_BITS(16)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .point_x   (point_x),
    .point_y   (point_y),
    .last_point(last_point),
    .span_error(span_error)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int mag(int v);
    return (v < 0) ? -v : v;
  endfunction

  // idle length: drawn from four ranges, the shortest most likely, the longest rare
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 90) return $urandom_range(3, 8);
    if (r < 98) return $urandom_range(9, 20);
    return $urandom_range(30, 80);
  endfunction

  // expected point words of one line request, appended to line_points
  task automatic push_line_points(input logic signed [15:0] sx, input logic signed [15:0] sy,
                                  input logic signed [15:0] ex, input logic signed [15:0] ey);
    int     x0, y0, dx, dy, dmaj, dmin, span, dir, i, q, off, px, py;
    bit     x_major;
    point_t p;
    x0 = sx;
    y0 = sy;
    dx = int'(ex) - x0;
    dy = int'(ey) - y0;
    x_major = mag(dx) >= mag(dy);
    dmaj = x_major ? dx : dy;
    dmin = x_major ? dy : dx;
    span = mag(dmaj);
    dir = (dmaj < 0) ? -1 : 1;
    n_lines++;
    if (span == 0 || span > SPAN_LIMIT) begin
      // equal endpoints or an over-long span: the start point alone
      p.x = sx;
      p.y = sy;
      p.last = 1'b1;
      p.err = (span != 0);
      line_points.insert(line_points.size(), p);
      if (span == 0) n_single++;
      else n_over++;
      return;
    end
    for (i = 0; i <= span; i++) begin
      // minor offset rounded half away from zero, exact in integers
      q = (2 * i * mag(dmin) + span) / (2 * span);
      off = (dmin < 0) ? -q : q;
      px = x_major ? x0 + i * dir : x0 + off;
      py = x_major ? y0 + off : y0 + i * dir;
      p.x = px[15:0];
      p.y = py[15:0];
      p.last = (i == span);
      p.err = 1'b0;
      line_points.insert(line_points.size(), p);
    end
  endtask

  task automatic add_req(input int sx, input int sy, input int ex, input int ey,
                         input bit drain_first);
    line_req_t r;
    int        idx;
    idx = line_reqs.size();
    r.sx = sx[15:0];
    r.sy = sy[15:0];
    r.ex = ex[15:0];
    r.ey = ey[15:0];
    r.drain_first = drain_first;
    // back-to-back stretches, one of them while the receiver holds off
    if ((idx >= 30 && idx < 55) || (idx >= HOLD_AT - 2 && idx < HOLD_AT + 20) ||
        (idx >= 260 && idx < 290) || $urandom_range(0, 1) == 0)
      r.gap = 0;
    else
      r.gap = idle_len();
    line_reqs.insert(line_reqs.size(), r);
  endtask

  // a line of the given major span kept inside the coordinate range
  task automatic add_line(input int span, input bit tie, input bit drain_first);
    int  dmaj, dmin, dx, dy, lo_x, hi_x, lo_y, hi_y, sx, sy;
    bit  x_major;
    dmaj = ($urandom_range(0, 1) == 0) ? span : -span;
    if (tie) dmin = ($urandom_range(0, 1) == 0) ? span : -span;
    else dmin = int'($urandom_range(0, 2 * span)) - span;
    x_major = ($urandom_range(0, 1) == 1);
    dx = x_major ? dmaj : dmin;
    dy = x_major ? dmin : dmaj;
    lo_x = (dx < 0) ? -32768 - dx : -32768;
    hi_x = (dx > 0) ? 32767 - dx : 32767;
    lo_y = (dy < 0) ? -32768 - dy : -32768;
    hi_y = (dy > 0) ? 32767 - dy : 32767;
    case ($urandom_range(0, 9))
      0: begin
        sx = lo_x;
        sy = lo_y;
      end
      1: begin
        sx = hi_x;
        sy = hi_y;
      end
      default: begin
        sx = lo_x + int'($urandom_range(0, hi_x - lo_x));
        sy = lo_y + int'($urandom_range(0, hi_y - lo_y));
      end
    endcase
    add_req(sx, sy, sx + dx, sy + dy, drain_first);
  endtask

  // stimulus, reset and the end of the run
  initial begin
    int i, r, px, py;
    // directed part
    add_req(0, 0, 0, 0, 1'b0);
    add_req(-32768, -32768, -32768, -32768, 1'b0);
    add_req(32767, 32767, 32767, 32767, 1'b0);
    add_req(-32768, -32768, 32767, 32767, 1'b0);
    add_req(32767, -32768, -32768, 32767, 1'b0);
    add_req(0, 0, 64, 0, 1'b0);
    add_req(0, 0, 0, -64, 1'b0);
    add_req(-32768, -32768, -32705, -32768, 1'b0);
    add_req(32767, 32767, 32767, 32704, 1'b0);
    add_req(0, 0, 1, 0, 1'b0);
    add_req(0, 0, 0, 1, 1'b0);
    add_req(0, 0, 4, 2, 1'b0);
    add_req(0, 0, 4, -2, 1'b0);
    add_req(0, 0, -4, 2, 1'b0);
    add_req(0, 0, 2, -4, 1'b0);
    add_req(0, 0, -2, -4, 1'b0);
    add_req(10, 10, 15, 15, 1'b0);
    add_req(10, 10, 5, 15, 1'b0);
    add_req(0, 0, 63, -63, 1'b0);
    add_req(0, 0, 63, 62, 1'b0);
    add_req(0, 0, -63, 1, 1'b0);
    add_req(100, -100, 99, -163, 1'b0);
    add_req(32767, 0, 32704, 7, 1'b0);
    add_req(-5, 7, 3, -2, 1'b0);
    // random part: mostly legal lines, short spans favored
    for (i = 0; i < RAND_LINES; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60)
        add_line(($urandom_range(0, 9) < 7) ? $urandom_range(1, 16) : $urandom_range(17, 63),
                 1'b0, (i == 125 || i == 215));
      else if (r < 68)
        add_line($urandom_range(62, 63), 1'b0, 1'b0);
      else if (r < 75) begin
        px = int'($urandom_range(0, 65535)) - 32768;
        py = int'($urandom_range(0, 65535)) - 32768;
        add_req(px, py, px, py, 1'b0);
      end else if (r < 82)
        add_line($urandom_range(1, 63), 1'b1, 1'b0);
      else if (r < 90)
        add_line($urandom_range(64, 1000), 1'b0, 1'b0);
      else
        add_req($urandom(), $urandom(), $urandom(), $urandom(), 1'b0);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // let everything drain, then give the block a few idle cycles
    do @(negedge clk); while (line_reqs.size() != 0 || in_valid);
    do @(negedge clk); while (outstanding != 0);
    repeat (20) @(negedge clk);

    $display("run covered %0d line requests (%0d over-span, %0d single point)",
             n_lines, n_over, n_single);
    $display("%0d point words checked in %0d cycles", n_words, cycle);
    if (n_fail == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // request driver: holds a word until taken, idles before a word when its gap asks for it
  always @(posedge clk) begin
    bit took;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && !in_stall;
      if (took) n_accepted <= n_accepted + 1;
      if (in_valid && !took) begin
        // stalled: payload stays put
      end else if (line_reqs.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        if (!gap_loaded) begin
          gap_left = line_reqs[0].gap;
          gap_loaded = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (line_reqs[0].drain_first && (took || outstanding != 0)) begin
          // pause until every point of earlier requests came out
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          start_x <= line_reqs[0].sx;
          start_y <= line_reqs[0].sy;
          end_x <= line_reqs[0].ex;
          end_y <= line_reqs[0].ey;
          void'(line_reqs.pop_front());
          gap_loaded = 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted on its own
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt <= 0;
    end else if (!hold_done && n_accepted == HOLD_AT) begin
      hold_cnt <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // point receiver: random stalls, calm windows with no new ones, and the long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (cycle % 256 == 0) calm <= ($urandom_range(0, 2) == 0);
      if (hold_cnt > 0) begin
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left <= idle_len() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor: checks point words, predicts points of each accepted request
  always @(posedge clk) begin
    point_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        n_words++;
        if (line_points.size() == 0) begin
          $error("point word with none expected: x=%0d y=%0d", $signed(point_x),
                 $signed(point_y));
          n_fail++;
        end else begin
          want = line_points.pop_front();
          if (point_x !== want.x) begin
            $error("point_x: expected %0d, got %0d", $signed(want.x), $signed(point_x));
            n_fail++;
          end
          if (point_y !== want.y) begin
            $error("point_y: expected %0d, got %0d", $signed(want.y), $signed(point_y));
            n_fail++;
          end
          if (last_point !== want.last) begin
            $error("last_point: expected %0b, got %0b", want.last, last_point);
            n_fail++;
          end
          if (span_error !== want.err) begin
            $error("span_error: expected %0b, got %0b", want.err, span_error);
            n_fail++;
          end
        end
      end
      if (in_valid && !in_stall) push_line_points(start_x, start_y, end_x, end_y);
      outstanding <= line_points.size();
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d points still due", cycle, line_points.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule
